### rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg: shared types and constants of the midpoint circle rasterizer
// Field widths, register indexes and the control structures that pass
// between the controller, the loop datapath and the offset pipeline.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int DIAM_W     = 5;
	localparam int IN_COORD_W = 12;
	localparam int COLOR_W    = 32;
	localparam int PT_W       = 13;
	localparam int OFF_W      = 27;
	localparam int PITCH_W    = 15;
	localparam int BPP_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 88;
	localparam int ITER_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BPP       = 2'd1;

	localparam logic [PITCH_W-1:0] PITCH_RESET = 15'd4096;
	localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;

	localparam logic [2:0]        LAST_OCTANT = 3'd7;
	localparam logic [ITER_W-1:0] LAST_ITER   = 3'd6;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic [2:0] octant;
	} dp_cmd_t;

	typedef struct packed {
		logic valid;
		logic last;
	} emit_t;

	typedef struct packed {
		logic [PT_W-1:0]    x;
		logic [PT_W-1:0]    y;
		logic [COLOR_W-1:0] color;
	} point_t;

endpackage

### rtl/mcr_ctrl.sv
// ----------------------------------------------------------------------------
// mcr_ctrl: sequencer of the midpoint circle rasterizer
// Takes a request, walks the eight octants of every loop iteration and
// tells the datapath when to load, when to advance the loop and when a
// pixel write enters the offset pipeline.
// ----------------------------------------------------------------------------
module mcr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             req_nonzero,
	input  logic             cont,
	input  logic             pipe_en,
	output mcr_pkg::dp_cmd_t cmd,
	output mcr_pkg::emit_t   emit
);
	import mcr_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [2:0]  octant_q;
	logic        at_last_octant;

	assign at_last_octant = (octant_q == LAST_OCTANT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			octant_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				octant_q <= '0;
			end else if (emit.valid) begin
				octant_q <= octant_q + 3'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && req_nonzero) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (pipe_en && at_last_octant && !cont) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.octant = octant_q;
		emit.valid = 1'b0;
		emit.last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid && req_nonzero;
			end
			ST_RUN: begin
				emit.valid = pipe_en;
				cmd.step   = pipe_en && at_last_octant;
				emit.last  = pipe_en && at_last_octant && !cont;
			end
			default: ;
		endcase
	end

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !pipe_en) |=> $stable(octant_q))
		else $error("octant moved while the pipeline was stalled");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit.last |=> (state_q == ST_IDLE))
		else $error("sequencer kept running after the last write");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == ST_IDLE && s_tready))
		else $error("request loaded while a circle was in progress");

	a_last_on_octant: assert property (@(posedge clk) disable iff (!arst_n)
		emit.last |-> (emit.valid && octant_q == LAST_OCTANT))
		else $error("last write marked away from the final octant");

endmodule

### rtl/mcr_dp.sv
// ----------------------------------------------------------------------------
// mcr_dp: loop datapath of the midpoint circle rasterizer
// Holds the doubled center, the doubled offsets and the scaled decision
// value, mirrors the offsets into the current octant and advances the loop.
// ----------------------------------------------------------------------------
module mcr_dp #(
	parameter int COORD_BITS   = 12,
	parameter int MAX_DIAMETER = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mcr_pkg::dp_cmd_t                       cmd,
	input  logic [mcr_pkg::DIAM_W-1:0]             req_diameter,
	input  logic [mcr_pkg::IN_COORD_W-1:0]         req_top_row,
	input  logic [mcr_pkg::IN_COORD_W-1:0]         req_left_col,
	input  logic [mcr_pkg::COLOR_W-1:0]            req_color,
	output logic                                   cont,
	output mcr_pkg::point_t                        point
);
	import mcr_pkg::*;

	localparam int OW = $clog2(MAX_DIAMETER + 1);
	localparam int XW = OW + 2;
	localparam int PW = OW + 6;
	localparam int CW = COORD_BITS + 2;

	logic [DIAM_W-1:0]       d_sat;
	logic [COORD_BITS-1:0]   row_m, col_m;
	logic [CW-1:0]           c2x_q, c2y_q;
	logic [COLOR_W-1:0]      color_q;
	logic signed [XW-1:0]    x2_q, y2_q, x2_n, y2_n;
	logic signed [PW-1:0]    p4_q, p4_n, p4_init, x2_ext, y2_ext;
	logic [ITER_W-1:0]       iter_q;
	logic [OW-1:0]           off_col, off_row;
	logic [CW-1:0]           col2, row2;

	assign d_sat = (req_diameter > DIAM_W'(MAX_DIAMETER)) ? DIAM_W'(MAX_DIAMETER)
	                                                      : req_diameter;
	assign row_m = COORD_BITS'(req_top_row);
	assign col_m = COORD_BITS'(req_left_col);

	assign p4_init = (d_sat[0] ? PW'(7) : PW'(8)) - PW'({d_sat, 1'b0});

	assign x2_ext = PW'(x2_q);
	assign y2_ext = PW'(y2_q);

	always_comb begin
		x2_n = x2_q + XW'(2);
		if (p4_q < 0) begin
			p4_n = p4_q + (x2_ext <<< 2) + PW'(12);
			y2_n = y2_q;
		end else begin
			p4_n = p4_q + ((x2_ext - y2_ext) <<< 2) + PW'(20);
			y2_n = y2_q - XW'(2);
		end
	end

	assign cont = (x2_n <= y2_n) && (iter_q < LAST_ITER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.load) begin
			iter_q <= '0;
		end else if (cmd.step) begin
			iter_q <= iter_q + ITER_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c2x_q   <= CW'({col_m, 1'b0}) + CW'(d_sat) - CW'(1);
			c2y_q   <= CW'({row_m, 1'b0}) + CW'(d_sat) - CW'(1);
			color_q <= req_color;
			x2_q    <= d_sat[0] ? XW'(0) : XW'(1);
			y2_q    <= XW'(d_sat) - XW'(1);
			p4_q    <= p4_init;
		end else if (cmd.step) begin
			x2_q <= x2_n;
			y2_q <= y2_n;
			p4_q <= p4_n;
		end
	end

	assign off_col = cmd.octant[2] ? y2_q[OW-1:0] : x2_q[OW-1:0];
	assign off_row = cmd.octant[2] ? x2_q[OW-1:0] : y2_q[OW-1:0];
	assign col2 = cmd.octant[1] ? (c2x_q - CW'(off_col)) : (c2x_q + CW'(off_col));
	assign row2 = cmd.octant[0] ? (c2y_q - CW'(off_row)) : (c2y_q + CW'(off_row));

	assign point.x     = PT_W'(col2 >> 1);
	assign point.y     = PT_W'(row2 >> 1);
	assign point.color = color_q;

endmodule

### rtl/mcr_addr.sv
// ----------------------------------------------------------------------------
// mcr_addr: offset pipeline of the midpoint circle rasterizer
// Registers each pixel write, forms row and column products, adds them into
// the byte offset and holds the finished word for the output channel.
// ----------------------------------------------------------------------------
module mcr_addr (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [mcr_pkg::PITCH_W-1:0]      row_pitch,
	input  logic [mcr_pkg::BPP_W-1:0]        bpp,
	input  mcr_pkg::emit_t                   emit,
	input  mcr_pkg::point_t                  point,
	output logic                             pipe_en,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// point_x[12:0], point_y[25:13], byte_offset[52:26], write_color[84:53]
	output logic [mcr_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                             m_tlast
);
	import mcr_pkg::*;

	localparam int PY_W = PT_W + PITCH_W;
	localparam int PX_W = PT_W + BPP_W;

	logic                 v_s1, v_s2, out_valid_q;
	logic                 last_s1, last_s2, last_q;
	point_t               pt_s1, pt_s2, pt_q;
	logic [PY_W-1:0]      prod_y_s2;
	logic [PX_W-1:0]      prod_x_s2;
	logic [OFF_W-1:0]     offset_q;

	assign pipe_en = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			v_s1        <= emit.valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pt_s1     <= point;
			last_s1   <= emit.last;
			pt_s2     <= pt_s1;
			last_s2   <= last_s1;
			prod_y_s2 <= PY_W'(pt_s1.y) * PY_W'(row_pitch);
			prod_x_s2 <= PX_W'(pt_s1.x) * PX_W'(bpp);
			pt_q      <= pt_s2;
			last_q    <= last_s2;
			offset_q  <= OFF_W'(prod_y_s2 + PY_W'(prod_x_s2));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {3'b000, pt_q.color, offset_q, pt_q.y, pt_q.x};

endmodule

### rtl/midpoint_circle_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit: midpoint circle rasterizer, top level
// Flow: the first pixel write of an accepted request passes the offset
// pipeline stages s1, s2 and the output register before it is offered;
// one write per cycle after that while the output is not stalled. Up to
// 56 writes per circle, eight per loop iteration; the next request is
// taken the cycle after the last write leaves the sequencer.
// Reset: asynchronous, active low; idles the sequencer, empties the pipeline.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit #(
	parameter int MAX_DIAMETER = 16,
	parameter int COORD_BITS   = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// circle_diameter[4:0], box_top_row[16:5], box_left_col[28:17],
	// pixel_color[60:29]
	input  logic [mcr_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// point_x[12:0], point_y[25:13], byte_offset[52:26], write_color[84:53]
	output logic [mcr_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [mcr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mcr_pkg::*;

	logic [PITCH_W-1:0]    row_pitch_q;
	logic [BPP_W-1:0]      bpp_q;
	logic [DIAM_W-1:0]     req_diameter;
	logic [IN_COORD_W-1:0] req_top_row, req_left_col;
	logic [COLOR_W-1:0]    req_color;
	logic                  cont, pipe_en;
	dp_cmd_t               cmd;
	emit_t                 emit;
	point_t                point;

	assign req_diameter = s_tdata[4:0];
	assign req_top_row  = s_tdata[16:5];
	assign req_left_col = s_tdata[28:17];
	assign req_color    = s_tdata[60:29];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pitch_q <= PITCH_RESET;
			bpp_q       <= BPP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_PITCH: row_pitch_q <= cfg_data;
				REG_BPP:       bpp_q       <= cfg_data[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	mcr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.req_nonzero (req_diameter != '0),
		.cont        (cont),
		.pipe_en     (pipe_en),
		.cmd         (cmd),
		.emit        (emit)
	);

	mcr_dp #(
		.COORD_BITS   (COORD_BITS),
		.MAX_DIAMETER (MAX_DIAMETER)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_diameter (req_diameter),
		.req_top_row  (req_top_row),
		.req_left_col (req_left_col),
		.req_color    (req_color),
		.cont         (cont),
		.point        (point)
	);

	mcr_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_pitch (row_pitch_q),
		.bpp       (bpp_q),
		.emit      (emit),
		.point     (point),
		.pipe_en   (pipe_en),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
